/* rtl/pbl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the page buffer LRU manager.
package pbl_pkg;

  localparam int unsigned FrameCountDef = 64;
  localparam int unsigned PageBitsDef   = 20;
  localparam int unsigned PageW         = 20;
  localparam int unsigned FrameW        = 6;
  localparam int unsigned TotalW        = 32;
  localparam int unsigned PageMaxW      = 32;

  typedef enum logic [1:0] {
    ACT_FIX       = 2'd0,
    ACT_SET_DIRTY = 2'd1,
    ACT_CLR_DIRTY = 2'd2,
    ACT_FLUSH     = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_PG,
    ST_SCAN_CMP,
    ST_FIX_TAIL,
    ST_FIX_END,
    ST_DIRTY,
    ST_FL_RD,
    ST_FL_PG,
    ST_FL_CHK,
    ST_FL_END
  } state_e;

  typedef struct packed {
    logic load;
    logic rank_inc;
    logic ord_rd;
    logic ord_shift;
    logic fl_fetch;
    logic tail_wr;
    logic fix_hit;
    logic fix_miss;
    logic dirty_upd;
    logic flush_chk;
    logic flush_end;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic full;
    logic match;
  } stat_t;

endpackage

/* rtl/pbl_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the page buffer LRU manager.
module pbl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     action_i,
  input  pbl_pkg::stat_t stat_i,
  output pbl_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import pbl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (action_e'(action_i)) inside
            ACT_FIX:                    state_d = ST_SCAN_RD;
            ACT_SET_DIRTY, ACT_CLR_DIRTY: state_d = ST_DIRTY;
            ACT_FLUSH:                  state_d = ST_FL_RD;
            default:                    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (stat_i.scan_end) begin
          state_d = stat_i.full ? ST_FIX_END : ST_FIX_TAIL;
        end else begin
          state_d = ST_SCAN_PG;
        end
      end
      ST_SCAN_PG:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = stat_i.match ? ST_IDLE : ST_SCAN_RD;
      ST_FIX_TAIL: state_d = ST_FIX_END;
      ST_FIX_END:  state_d = ST_IDLE;
      ST_DIRTY:    state_d = ST_IDLE;
      ST_FL_RD:    state_d = stat_i.scan_end ? ST_FL_END : ST_FL_PG;
      ST_FL_PG:    state_d = ST_FL_CHK;
      ST_FL_CHK:   state_d = ST_FL_RD;
      ST_FL_END:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SCAN_RD:  cmd_o.ord_rd = !stat_i.scan_end;
      ST_SCAN_PG:  cmd_o.ord_shift = 1'b1;
      ST_SCAN_CMP: begin
        cmd_o.fix_hit  = stat_i.match;
        cmd_o.rank_inc = !stat_i.match;
      end
      ST_FIX_TAIL: cmd_o.tail_wr = 1'b1;
      ST_FIX_END:  cmd_o.fix_miss = 1'b1;
      ST_DIRTY:    cmd_o.dirty_upd = 1'b1;
      ST_FL_RD:    cmd_o.ord_rd = !stat_i.scan_end;
      ST_FL_PG:    cmd_o.fl_fetch = 1'b1;
      ST_FL_CHK: begin
        cmd_o.flush_chk = 1'b1;
        cmd_o.rank_inc  = 1'b1;
      end
      ST_FL_END:   cmd_o.flush_end = 1'b1;
      default:     busy_o = 1'b1;
    endcase
  end

  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q != ST_IDLE)
    else $error("accepted request did not start work");

  a_hit_ends_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fix_hit |=> state_q == ST_IDLE)
    else $error("hit did not end the fix");

  a_scan_end_stops_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.scan_end |-> !cmd_o.ord_rd)
    else $error("order read past the used ranks");

endmodule

/* rtl/pbl_datapath.sv */
`timescale 1ns / 1ps
// Frame store, recency order, dirty marks, counters and result register.
module pbl_datapath #(
  parameter int unsigned FRAME_COUNT = pbl_pkg::FrameCountDef,
  parameter int unsigned PAGE_BITS   = pbl_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pbl_pkg::cmd_t                 cmd_i,
  output pbl_pkg::stat_t                stat_o,
  input  logic [1:0]                    action_i,
  input  logic [pbl_pkg::PageW-1:0]     page_number_i,
  input  logic [pbl_pkg::FrameW-1:0]    frame_number_i,
  output logic                          out_valid_o,
  output logic [pbl_pkg::FrameW-1:0]    frame_out_o,
  output logic                          was_hit_o,
  output logic                          read_request_o,
  output logic                          writeback_request_o,
  output logic [pbl_pkg::PageW-1:0]     writeback_page_o,
  output logic [pbl_pkg::FrameW-1:0]    writeback_frame_o,
  output logic [pbl_pkg::TotalW-1:0]    hit_total_o,
  output logic [pbl_pkg::TotalW-1:0]    io_total_o,
  output logic                          last_result_o
);
  import pbl_pkg::*;

  localparam int unsigned FW = $clog2(FRAME_COUNT);
  localparam int unsigned CW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned NW = FrameW + 1;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // request
  logic [PAGE_BITS-1:0] page_q;
  logic [FrameW-1:0]    fnum_q;
  logic                 set_q;
  logic [PageMaxW-1:0]  page_ext;

  // control state
  logic [CW-1:0]          rank_q, used_q;
  logic [TotalW-1:0]      hit_cnt_q, io_cnt_q;
  logic                   pend_v_q;

  // payload
  logic [FW-1:0]        carry_q, pend_frame_q;
  logic [PAGE_BITS-1:0] pend_page_q;

  // memories: recency order (rank -> frame), frame contents and dirty marks
  logic [FW-1:0]        order_mem [FRAME_COUNT];
  logic [PAGE_BITS-1:0] page_mem  [FRAME_COUNT];
  logic                 dirty_mem [FRAME_COUNT];
  logic [FW-1:0]        ord_rdata_q;
  logic [PAGE_BITS-1:0] pg_rdata_q;
  logic                 dirty_rdata_q;

  logic          ord_we;
  logic [FW-1:0] ord_waddr, ord_wdata, miss_frame;
  logic          pg_re, fnum_ok, carry_dirty;
  logic          dirty_we, dirty_wdata;
  logic [FW-1:0] dirty_waddr;

  // result being formed
  logic                 emit, e_hit, e_rd, e_wb, e_last, hit_inc, io_inc;
  logic [FW-1:0]        e_frame, e_wbf;
  logic [PAGE_BITS-1:0] e_wbp;
  logic [PageMaxW-1:0]  e_wbp_ext;

  logic                 res_valid_q, res_hit_q, res_rd_q, res_wb_q, res_last_q;
  logic [FW-1:0]        res_frame_q, res_wbf_q;
  logic [PageW-1:0]     res_wbp_q;

  assign page_ext    = PageMaxW'(page_number_i);
  assign stat_o.scan_end = (rank_q == used_q);
  assign stat_o.full     = (used_q == CW'(FRAME_COUNT));
  assign stat_o.match    = (pg_rdata_q == page_q);
  assign miss_frame  = stat_o.full ? carry_q : used_q[FW-1:0];
  assign carry_dirty = dirty_rdata_q;
  assign fnum_ok     = {1'b0, fnum_q} < NW'(used_q);

  assign ord_we    = cmd_i.ord_shift | cmd_i.tail_wr | cmd_i.fix_hit | cmd_i.fix_miss;
  assign ord_waddr = (cmd_i.fix_hit | cmd_i.fix_miss) ? '0 : rank_q[FW-1:0];
  assign ord_wdata = cmd_i.fix_miss ? miss_frame : carry_q;
  assign pg_re     = cmd_i.ord_shift | cmd_i.fl_fetch;

  // a frame's mark is written when it is filled, before it can be read
  assign dirty_we    = cmd_i.fix_miss | (cmd_i.dirty_upd & fnum_ok);
  assign dirty_waddr = cmd_i.fix_miss ? miss_frame : fnum_q[FW-1:0];
  assign dirty_wdata = !cmd_i.fix_miss && set_q;

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (cmd_i.ord_rd) begin
      ord_rdata_q <= order_mem[rank_q[FW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix_miss) begin
      page_mem[miss_frame] <= page_q;
    end
    if (pg_re) begin
      pg_rdata_q <= page_mem[ord_rdata_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dirty_we) begin
      dirty_mem[dirty_waddr] <= dirty_wdata;
    end
    if (pg_re) begin
      dirty_rdata_q <= dirty_mem[ord_rdata_q];
    end
  end

  always_comb begin
    emit    = 1'b0;
    e_frame = '0;
    e_hit   = 1'b0;
    e_rd    = 1'b0;
    e_wb    = 1'b0;
    e_wbp   = '0;
    e_wbf   = '0;
    e_last  = 1'b0;
    hit_inc = 1'b0;
    io_inc  = 1'b0;
    if (cmd_i.fix_hit) begin
      emit    = 1'b1;
      e_frame = carry_q;
      e_hit   = 1'b1;
      e_last  = 1'b1;
      hit_inc = 1'b1;
    end
    if (cmd_i.fix_miss) begin
      emit    = 1'b1;
      e_frame = miss_frame;
      e_rd    = 1'b1;
      e_last  = 1'b1;
      io_inc  = 1'b1;
      if (stat_o.full && carry_dirty) begin
        e_wb  = 1'b1;
        e_wbp = pg_rdata_q;
        e_wbf = carry_q;
      end
    end
    if (cmd_i.dirty_upd) begin
      emit   = 1'b1;
      e_last = 1'b1;
    end
    // a flush transfer waits for the next one, so that the final one can carry last
    if (cmd_i.flush_chk && carry_dirty && pend_v_q) begin
      emit   = 1'b1;
      e_wb   = 1'b1;
      e_wbp  = pend_page_q;
      e_wbf  = pend_frame_q;
      io_inc = 1'b1;
    end
    if (cmd_i.flush_end) begin
      emit   = 1'b1;
      e_last = 1'b1;
      if (pend_v_q) begin
        e_wb   = 1'b1;
        e_wbp  = pend_page_q;
        e_wbf  = pend_frame_q;
        io_inc = 1'b1;
      end
    end
  end

  assign e_wbp_ext = PageMaxW'(e_wbp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= '0;
      used_q      <= '0;
      hit_cnt_q   <= '0;
      io_cnt_q    <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
      if (cmd_i.load) begin
        rank_q   <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.rank_inc) begin
        rank_q <= rank_q + 1'b1;
      end
      if (cmd_i.fix_miss) begin
        if (!stat_o.full) begin
          used_q <= used_q + 1'b1;
        end
      end
      if (cmd_i.flush_chk && carry_dirty) begin
        pend_v_q <= 1'b1;
      end
      if (hit_inc) begin
        hit_cnt_q <= sat_inc(hit_cnt_q);
      end
      if (io_inc) begin
        io_cnt_q <= sat_inc(io_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_ext[PAGE_BITS-1:0];
      fnum_q <= frame_number_i;
      set_q  <= (action_e'(action_i) == ACT_SET_DIRTY);
    end
    if (cmd_i.ord_shift || cmd_i.fl_fetch) begin
      carry_q <= ord_rdata_q;
    end
    if (cmd_i.flush_chk && carry_dirty) begin
      pend_page_q  <= pg_rdata_q;
      pend_frame_q <= carry_q;
    end
    if (emit) begin
      res_frame_q <= e_frame;
      res_hit_q   <= e_hit;
      res_rd_q    <= e_rd;
      res_wb_q    <= e_wb;
      res_wbp_q   <= e_wbp_ext[PageW-1:0];
      res_wbf_q   <= e_wbf;
      res_last_q  <= e_last;
    end
  end

  assign out_valid_o         = res_valid_q;
  assign frame_out_o         = FrameW'(res_frame_q);
  assign was_hit_o           = res_hit_q;
  assign read_request_o      = res_rd_q;
  assign writeback_request_o = res_wb_q;
  assign writeback_page_o    = res_wbp_q;
  assign writeback_frame_o   = FrameW'(res_wbf_q);
  assign hit_total_o         = hit_cnt_q;
  assign io_total_o          = io_cnt_q;
  assign last_result_o       = res_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix_miss && !stat_o.full |=> used_q == $past(used_q) + 1'b1)
    else $error("frame fill count did not advance on a miss");

  a_hit_cnt_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hit_cnt_q) |-> res_valid_q && res_hit_q)
    else $error("hit count moved without a hit transfer");

  a_io_cnt_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(io_cnt_q) |-> res_valid_q && (res_rd_q || res_wb_q))
    else $error("io count moved without a read or write-back transfer");

endmodule

/* rtl/page_buffer_lru_manager.sv */
`timescale 1ns / 1ps
// Top level of the page buffer LRU manager.
//
// Usage: a request is taken on a rising edge with start_i high and busy_o low.
// action_i selects fix page, set dirty, clear dirty or flush. Results appear
// for one cycle each, marked by out_valid_o; last_result_o flags the final
// transfer of a request. The receiver cannot stall, so none is ever held.
// Walk: the recency order is walked one rank at a time, from the most recent,
// reading the order memory, then the frame's page and dirty mark, then checking
// them. A fix ends at the rank whose page matches or, on a miss, after all ranks
// in use. A flush gives one transfer per dirty frame, most recent first, or a
// single empty one when nothing is dirty.
// busy_o is high for the whole of a request; the next one can start in the
// cycle its last result is shown.
// Reset: all frames unused and both totals cleared; a frame's dirty mark is
// written when the frame is first filled, so no clearing pass is needed and
// the block takes requests straight out of reset.
module page_buffer_lru_manager #(
  parameter int unsigned FRAME_COUNT = pbl_pkg::FrameCountDef,
  parameter int unsigned PAGE_BITS   = pbl_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic [pbl_pkg::PageW-1:0]     page_number_i,
  input  logic [pbl_pkg::FrameW-1:0]    frame_number_i,
  output logic                          out_valid_o,
  output logic [pbl_pkg::FrameW-1:0]    frame_out_o,
  output logic                          was_hit_o,
  output logic                          read_request_o,
  output logic                          writeback_request_o,
  output logic [pbl_pkg::PageW-1:0]     writeback_page_o,
  output logic [pbl_pkg::FrameW-1:0]    writeback_frame_o,
  output logic [pbl_pkg::TotalW-1:0]    hit_total_o,
  output logic [pbl_pkg::TotalW-1:0]    io_total_o,
  output logic                          last_result_o
);
  import pbl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pbl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pbl_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .action_i            (action_i),
    .page_number_i       (page_number_i),
    .frame_number_i      (frame_number_i),
    .out_valid_o         (out_valid_o),
    .frame_out_o         (frame_out_o),
    .was_hit_o           (was_hit_o),
    .read_request_o      (read_request_o),
    .writeback_request_o (writeback_request_o),
    .writeback_page_o    (writeback_page_o),
    .writeback_frame_o   (writeback_frame_o),
    .hit_total_o         (hit_total_o),
    .io_total_o          (io_total_o),
    .last_result_o       (last_result_o)
  );

endmodule
